@@ hw/rtl/v3n_pkg.sv @@
// Shared opcodes, status codes, defaults and control types of the vector ALU.
package v3n_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned EpsWidth     = 16;
  localparam logic [EpsWidth-1:0] EpsReset = 16'd66;

  typedef logic [3:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OpAdd    = 4'd0;
  localparam op_t OpSub    = 4'd1;
  localparam op_t OpDot    = 4'd2;
  localparam op_t OpCross  = 4'd3;
  localparam op_t OpScale  = 4'd4;
  localparam op_t OpDiv    = 4'd5;
  localparam op_t OpNeg    = 4'd6;
  localparam op_t OpLength = 4'd7;
  localparam op_t OpNorm   = 4'd8;

  localparam status_t StOk      = 2'd0;
  localparam status_t StSat     = 2'd1;
  localparam status_t StDivZero = 2'd2;

  typedef struct packed {
    op_t     op;
    status_t status;
  } ctl_t;

endpackage

@@ hw/rtl/v3n_in_if.sv @@
// Request channel of the vector ALU: opcode, two vectors and a scalar.
interface v3n_in_if #(
  parameter int unsigned DATA_WIDTH = v3n_pkg::DataWidthDef
) ();
  logic                  valid;
  logic                  ready;
  logic [3:0]            op;
  logic [DATA_WIDTH-1:0] a_x;
  logic [DATA_WIDTH-1:0] a_y;
  logic [DATA_WIDTH-1:0] a_z;
  logic [DATA_WIDTH-1:0] b_x;
  logic [DATA_WIDTH-1:0] b_y;
  logic [DATA_WIDTH-1:0] b_z;
  logic [DATA_WIDTH-1:0] scalar_in;

  modport source (output valid, op, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, input ready);
  modport sink   (input valid, op, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, output ready);
endinterface

@@ hw/rtl/v3n_out_if.sv @@
// Result channel of the vector ALU: vector, scalar and status.
interface v3n_out_if #(
  parameter int unsigned DATA_WIDTH = v3n_pkg::DataWidthDef
) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] res_x;
  logic [DATA_WIDTH-1:0] res_y;
  logic [DATA_WIDTH-1:0] res_z;
  logic [DATA_WIDTH-1:0] res_scalar;
  logic [1:0]            status;

  modport source (output valid, res_x, res_y, res_z, res_scalar, status, input ready);
  modport sink   (input valid, res_x, res_y, res_z, res_scalar, status, output ready);
endinterface

@@ hw/rtl/vec3_alu_with_normalize.sv @@
// Top level of the Q-format three-component vector ALU with normalize.
//
//  channel   dir  handshake        contents
//  in_i      in   valid / ready    op, a_x..a_z, b_x..b_z, scalar_in
//  out_o     out  valid / ready    res_x..res_z, res_scalar, status
//  cfg       in   cfg_we_i only    cfg_wdata_i -> epsilon (16 bits)
//
// One request enters per cycle while out_o is not stalled. Every request runs the
// full pipeline: three front stages, one square-root stage per root bit, one
// decision stage, one divider stage per quotient bit and the output register.
// Reset clears every valid bit and loads epsilon with its default of 66.
// A stall on out_o freezes all stages together; nothing is dropped or doubled.
module vec3_alu_with_normalize #(
  parameter int unsigned DATA_WIDTH = v3n_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = v3n_pkg::FracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  v3n_in_if.sink                          in_i,
  v3n_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [v3n_pkg::EpsWidth-1:0]    cfg_wdata_i
);
  import v3n_pkg::*;

  localparam int unsigned W      = DATA_WIDTH;
  localparam int unsigned QW     = DATA_WIDTH + FRAC_BITS;
  localparam int unsigned CtlW   = $bits(ctl_t);
  localparam int unsigned SqSbW  = CtlW + 8 * DATA_WIDTH;
  localparam int unsigned DivSbW = CtlW + 4 * DATA_WIDTH + 4;
  localparam logic [W-1:0]  Vmax    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  Vmin    = {1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] QMaxPos = {{(FRAC_BITS+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [QW-1:0] QMaxNeg = {{FRAC_BITS{1'b0}}, 1'b1, {(W-1){1'b0}}};

  // global advance: move everything unless a finished result is held back
  logic en;
  logic out_valid_q;
  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // epsilon register
  logic [EpsWidth-1:0] eps_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsReset;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // front: multiply, sum, saturate the direct ops
  logic                 fr_valid;
  ctl_t                 fr_ctl;
  logic [2:0][W-1:0]    fr_vec, fr_a;
  logic [W-1:0]         fr_sc, fr_s;
  logic [2*W-1:0]       fr_sq;

  v3n_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .op_i    (in_i.op),
    .a_i     ({in_i.a_z, in_i.a_y, in_i.a_x}),
    .b_i     ({in_i.b_z, in_i.b_y, in_i.b_x}),
    .s_i     (in_i.scalar_in),
    .valid_o (fr_valid),
    .ctl_o   (fr_ctl),
    .vec_o   (fr_vec),
    .sc_o    (fr_sc),
    .sq_o    (fr_sq),
    .a_o     (fr_a),
    .s_o     (fr_s)
  );

  // square root of the sum of squares; the rest rides along as sideband
  logic              sq_valid;
  logic [W-1:0]      sq_root;
  logic [SqSbW-1:0]  sq_sb;
  ctl_t              sq_ctl;
  logic [2:0][W-1:0] sq_vec, sq_a;
  logic [W-1:0]      sq_sc, sq_s;

  v3n_sqrt #(
    .DATA_WIDTH (DATA_WIDTH),
    .SB_WIDTH   (SqSbW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .sq_i    (fr_sq),
    .sb_i    ({fr_ctl, fr_vec, fr_sc, fr_a, fr_s}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  assign {sq_ctl, sq_vec, sq_sc, sq_a, sq_s} = sq_sb;

  // decision stage: length result, divisor choice, operand magnitudes
  logic              dv_q;
  ctl_t              dctl_d, dctl_q;
  logic [W-1:0]      dsc_d, dsc_q;
  logic              dgo_d, dgo_q;
  logic [2:0]        dneg_d, dneg_q;
  logic [2:0][W-1:0] dmag_d, dmag_q;
  logic [W-1:0]      dden_d, dden_q;
  logic [2:0][W-1:0] dvec_q;

  always_comb begin
    dctl_d = sq_ctl;
    dsc_d  = sq_sc;
    dgo_d  = 1'b0;
    dden_d = sq_root;
    for (int l = 0; l < 3; l++) begin
      dmag_d[l] = sq_a[l][W-1] ? W'(~sq_a[l] + 1'b1) : sq_a[l];
      dneg_d[l] = sq_a[l][W-1];
    end
    unique case (sq_ctl.op)
      OpLength: begin
        // root is unsigned; its top bit set means above the signed range
        if (sq_root[W-1]) begin
          dsc_d         = Vmax;
          dctl_d.status = StSat;
        end else begin
          dsc_d = sq_root;
        end
      end
      OpNorm: begin
        dgo_d = (sq_root != '0) && (sq_root >= W'(eps_q));
      end
      OpDiv: begin
        dgo_d  = (sq_s != '0);
        dden_d = sq_s[W-1] ? W'(~sq_s + 1'b1) : sq_s;
        for (int l = 0; l < 3; l++) begin
          dneg_d[l] = sq_a[l][W-1] ^ sq_s[W-1];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= 1'b0;
    end else if (en) begin
      dv_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dctl_q <= dctl_d;
      dsc_q  <= dsc_d;
      dgo_q  <= dgo_d;
      dneg_q <= dneg_d;
      dmag_q <= dmag_d;
      dden_q <= dden_d;
      dvec_q <= sq_vec;
    end
  end

  // divider for divide and normalize
  logic                dv_valid;
  logic [2:0][QW-1:0]  dv_quo;
  logic [DivSbW-1:0]   dv_sb;
  ctl_t                dv_ctl;
  logic [2:0][W-1:0]   dv_vec;
  logic [W-1:0]        dv_sc;
  logic                dv_go;
  logic [2:0]          dv_neg;

  v3n_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .SB_WIDTH   (DivSbW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_q),
    .mag_i   (dmag_q),
    .den_i   (dden_q),
    .sb_i    ({dctl_q, dvec_q, dsc_q, dgo_q, dneg_q}),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .sb_o    (dv_sb)
  );

  assign {dv_ctl, dv_vec, dv_sc, dv_go, dv_neg} = dv_sb;

  // output register: sign and clamp the quotients, or pass the direct result
  logic [2:0][W-1:0] res_d, res_q;
  logic [W-1:0]      rsc_q;
  status_t           st_d, st_q;

  always_comb begin
    logic flag;
    flag  = 1'b0;
    res_d = dv_vec;
    st_d  = dv_ctl.status;
    if (dv_go) begin
      for (int l = 0; l < 3; l++) begin
        if (!dv_neg[l]) begin
          if (dv_quo[l] > QMaxPos) begin
            res_d[l] = Vmax;
            flag     = 1'b1;
          end else begin
            res_d[l] = dv_quo[l][W-1:0];
          end
        end else begin
          if (dv_quo[l] > QMaxNeg) begin
            res_d[l] = Vmin;
            flag     = 1'b1;
          end else begin
            res_d[l] = W'(~dv_quo[l][W-1:0] + 1'b1);
          end
        end
      end
      st_d = flag ? StSat : StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      rsc_q <= dv_sc;
      st_q  <= st_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.res_x      = res_q[0];
  assign out_o.res_y      = res_q[1];
  assign out_o.res_z      = res_q[2];
  assign out_o.res_scalar = rsc_q;
  assign out_o.status     = st_q;

endmodule

@@ hw/rtl/v3n_front.sv @@
// Front stages: operand register, six multipliers, sums and saturation.
module v3n_front #(
  parameter int unsigned DATA_WIDTH = v3n_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = v3n_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  v3n_pkg::op_t                  op_i,
  input  logic [2:0][DATA_WIDTH-1:0]    a_i,
  input  logic [2:0][DATA_WIDTH-1:0]    b_i,
  input  logic [DATA_WIDTH-1:0]         s_i,
  output logic                          valid_o,
  output v3n_pkg::ctl_t                 ctl_o,
  output logic [2:0][DATA_WIDTH-1:0]    vec_o,
  output logic [DATA_WIDTH-1:0]         sc_o,
  output logic [2*DATA_WIDTH-1:0]       sq_o,
  output logic [2:0][DATA_WIDTH-1:0]    a_o,
  output logic [DATA_WIDTH-1:0]         s_o
);
  import v3n_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned XW = 2 * DATA_WIDTH + 2;
  localparam logic signed [XW-1:0] VmaxX = {{(W+3){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] VminX = {{(W+3){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0] Vmax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] Vmin = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [XW-1:0] sx(input logic [W-1:0] x);
    return {{(W+2){x[W-1]}}, x};
  endfunction

  function automatic logic signed [XW-1:0] px(input logic [2*W-1:0] p);
    return {{2{p[2*W-1]}}, p};
  endfunction

  // bit W is the overflow flag
  function automatic logic [W:0] sat_fn(input logic signed [XW-1:0] v);
    logic [W:0] r;
    r = {1'b0, v[W-1:0]};
    if (v > VmaxX) begin
      r = {1'b1, Vmax};
    end else if (v < VminX) begin
      r = {1'b1, Vmin};
    end
    return r;
  endfunction

  // stage A: operands
  logic                 va_q;
  op_t                  opa_q;
  logic [2:0][W-1:0]    aa_q, ba_q;
  logic [W-1:0]         sa_q;

  // stage B: products
  logic                 vb_q;
  op_t                  opb_q;
  logic [2:0][W-1:0]    ab_q, bb_q;
  logic [W-1:0]         sb_q;
  logic [2*W-1:0]       pb_q [6];
  logic signed [W-1:0]  xm [6];
  logic signed [W-1:0]  ym [6];

  // stage C: results
  logic                 vc_q;
  ctl_t                 ctl_d, ctl_q;
  logic [2:0][W-1:0]    vec_d, vec_q;
  logic [W-1:0]         sc_d, sc_q;
  logic [2*W-1:0]       sq_d, sq_q;
  logic [2:0][W-1:0]    ac_q;
  logic [W-1:0]         sc_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      xm[k] = '0;
      ym[k] = '0;
    end
    unique case (opa_q)
      OpDot: begin
        for (int l = 0; l < 3; l++) begin
          xm[l] = aa_q[l];
          ym[l] = ba_q[l];
        end
      end
      OpCross: begin
        xm[0] = aa_q[1]; ym[0] = ba_q[2];
        xm[1] = aa_q[2]; ym[1] = ba_q[1];
        xm[2] = aa_q[2]; ym[2] = ba_q[0];
        xm[3] = aa_q[0]; ym[3] = ba_q[2];
        xm[4] = aa_q[0]; ym[4] = ba_q[1];
        xm[5] = aa_q[1]; ym[5] = ba_q[0];
      end
      OpScale: begin
        for (int l = 0; l < 3; l++) begin
          xm[l] = aa_q[l];
          ym[l] = sa_q;
        end
      end
      OpLength, OpNorm: begin
        for (int l = 0; l < 3; l++) begin
          xm[l] = aa_q[l];
          ym[l] = aa_q[l];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opa_q <= op_i;
      aa_q  <= a_i;
      ba_q  <= b_i;
      sa_q  <= s_i;
      opb_q <= opa_q;
      ab_q  <= aa_q;
      bb_q  <= ba_q;
      sb_q  <= sa_q;
      for (int k = 0; k < 6; k++) begin
        pb_q[k] <= xm[k] * ym[k];
      end
    end
  end

  always_comb begin
    logic signed [XW-1:0] t;
    logic [W:0]           r;
    logic                 flag;
    t     = '0;
    r     = '0;
    flag  = 1'b0;
    vec_d = '0;
    sc_d  = '0;
    ctl_d = '{op: opb_q, status: StOk};
    sq_d  = pb_q[0] + pb_q[1] + pb_q[2];
    unique case (opb_q)
      OpAdd, OpSub, OpNeg: begin
        for (int l = 0; l < 3; l++) begin
          if (opb_q == OpAdd) begin
            t = sx(ab_q[l]) + sx(bb_q[l]);
          end else if (opb_q == OpSub) begin
            t = sx(ab_q[l]) - sx(bb_q[l]);
          end else begin
            t = -sx(ab_q[l]);
          end
          r        = sat_fn(t);
          vec_d[l] = r[W-1:0];
          flag     = flag | r[W];
        end
      end
      OpDot: begin
        t    = (px(pb_q[0]) + px(pb_q[1]) + px(pb_q[2])) >>> FRAC_BITS;
        r    = sat_fn(t);
        sc_d = r[W-1:0];
        flag = r[W];
      end
      OpCross: begin
        for (int l = 0; l < 3; l++) begin
          t        = (px(pb_q[2*l]) - px(pb_q[2*l+1])) >>> FRAC_BITS;
          r        = sat_fn(t);
          vec_d[l] = r[W-1:0];
          flag     = flag | r[W];
        end
      end
      OpScale: begin
        for (int l = 0; l < 3; l++) begin
          t        = px(pb_q[l]) >>> FRAC_BITS;
          r        = sat_fn(t);
          vec_d[l] = r[W-1:0];
          flag     = flag | r[W];
        end
      end
      OpDiv: begin
        if (sb_q == '0) begin
          ctl_d.status = StDivZero;
        end
      end
      default: ;
    endcase
    if (flag) begin
      ctl_d.status = StSat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q  <= ctl_d;
      vec_q  <= vec_d;
      sc_q   <= sc_d;
      sq_q   <= sq_d;
      ac_q   <= ab_q;
      sc_s_q <= sb_q;
    end
  end

  assign valid_o = vc_q;
  assign ctl_o   = ctl_q;
  assign vec_o   = vec_q;
  assign sc_o    = sc_q;
  assign sq_o    = sq_q;
  assign a_o     = ac_q;
  assign s_o     = sc_s_q;

endmodule

@@ hw/rtl/v3n_sqrt.sv @@
// Pipelined floor square root, one result bit per stage, with sideband.
module v3n_sqrt #(
  parameter int unsigned DATA_WIDTH = v3n_pkg::DataWidthDef,
  parameter int unsigned SB_WIDTH   = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [2*DATA_WIDTH-1:0]   sq_i,
  input  logic [SB_WIDTH-1:0]       sb_i,
  output logic                      valid_o,
  output logic [DATA_WIDTH-1:0]     root_o,
  output logic [SB_WIDTH-1:0]       sb_o
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned RW = DATA_WIDTH + 1;

  logic [2*W-1:0]      v_q    [W];
  logic [RW-1:0]       rem_q  [W];
  logic [W-1:0]        root_q [W];
  logic                vld_q  [W];
  logic [SB_WIDTH-1:0] sb_q   [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [2*W-1:0]      v_in;
    logic [RW-1:0]       rem_in;
    logic [W-1:0]        root_in;
    logic                vld_in;
    logic [SB_WIDTH-1:0] sb_in;
    logic [RW+1:0]       rem_sh;
    logic [RW+1:0]       trial;

    if (k == 0) begin : g_first
      assign v_in    = sq_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign vld_in  = valid_i;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign vld_in  = vld_q[k-1];
      assign sb_in   = sb_q[k-1];
    end

    // bring down the next two radicand bits, try 4*root+1
    assign rem_sh = {rem_in, v_in[2*W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k]  <= v_in << 2;
        sb_q[k] <= sb_in;
        if (rem_sh >= trial) begin
          rem_q[k]  <= RW'(rem_sh - trial);
          root_q[k] <= {root_in[W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh[RW-1:0];
          root_q[k] <= {root_in[W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign root_o  = root_q[W-1];
  assign sb_o    = sb_q[W-1];

endmodule

@@ hw/rtl/v3n_div.sv @@
// Pipelined restoring divider, three lanes over one divisor, one bit per stage.
module v3n_div #(
  parameter int unsigned DATA_WIDTH = v3n_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = v3n_pkg::FracBitsDef,
  parameter int unsigned SB_WIDTH   = 1
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic [2:0][DATA_WIDTH-1:0]              mag_i,
  input  logic [DATA_WIDTH-1:0]                   den_i,
  input  logic [SB_WIDTH-1:0]                     sb_i,
  output logic                                    valid_o,
  output logic [2:0][DATA_WIDTH+FRAC_BITS-1:0]    quo_o,
  output logic [SB_WIDTH-1:0]                     sb_o
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned QW = DATA_WIDTH + FRAC_BITS;

  logic [2:0][W-1:0]   rem_q [QW];
  logic [2:0][QW-1:0]  nq_q  [QW];
  logic [W-1:0]        den_q [QW];
  logic                vld_q [QW];
  logic [SB_WIDTH-1:0] sb_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [2:0][W-1:0]   rem_in;
    logic [2:0][QW-1:0]  nq_in;
    logic [W-1:0]        den_in;
    logic                vld_in;
    logic [SB_WIDTH-1:0] sb_in;
    logic [2:0][W-1:0]   rem_nx;
    logic [2:0][QW-1:0]  nq_nx;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign nq_in[l] = {mag_i[l], {FRAC_BITS{1'b0}}};
      end
      assign den_in = den_i;
      assign vld_in = valid_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
      assign vld_in = vld_q[k-1];
      assign sb_in  = sb_q[k-1];
    end

    // dividend shifts out at the top while quotient bits shift in below
    always_comb begin
      logic [W:0] rem_sh;
      logic       ge;
      for (int l = 0; l < 3; l++) begin
        rem_sh    = {rem_in[l], nq_in[l][QW-1]};
        ge        = rem_sh >= {1'b0, den_in};
        rem_nx[l] = ge ? W'(rem_sh - {1'b0, den_in}) : rem_sh[W-1:0];
        nq_nx[l]  = {nq_in[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_nx;
        nq_q[k]  <= nq_nx;
        den_q[k] <= den_in;
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = nq_q[QW-1];
  assign sb_o    = sb_q[QW-1];

endmodule
